>>> rtl/core/lhr_pkg.sv
`timescale 1ns / 1ps

package lhr_pkg;

  localparam int unsigned HANDLER_W = 16;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned STATUS_W  = 3;

  localparam int unsigned LOW_SLOTS_DEF   = 256;
  localparam int unsigned SYS_SLOTS_DEF   = 64;
  localparam int unsigned USER_SLOTS_DEF  = 64;
  localparam int unsigned MAX_NUMBER_DEF  = 4095;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP     = 3'd0,
    OP_INSTALL    = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_NEXT_LOWER = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_SAME      = 3'd1,
    ST_CONFLICT  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_INVALID   = 3'd5
  } status_e;

endpackage

>>> rtl/core/library_handler_registry.sv
`timescale 1ns / 1ps
// Lookup, install and remove of a low or system number: a slot read, a check, then the result.
// A user number scans the user list entry by entry, and install or remove also shifts
// the entries behind it; next lower scans the tables entry by entry. One item at a time.
// Clear all runs the clearing pass below, empties the user list, then responds. After
// reset a clearing pass zeroes the slot memory with in_stall_o high.
module library_handler_registry #(
  parameter int unsigned LOW_SLOTS         = lhr_pkg::LOW_SLOTS_DEF,
  parameter int unsigned SYSTEM_HIGH_SLOTS = lhr_pkg::SYS_SLOTS_DEF,
  parameter int unsigned USER_SLOTS        = lhr_pkg::USER_SLOTS_DEF,
  parameter int unsigned MAX_NUMBER        = lhr_pkg::MAX_NUMBER_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lhr_pkg::OP_W-1:0]            op_i,
  input  logic [$clog2(MAX_NUMBER+1):0]       lib_number_i,
  input  logic [lhr_pkg::HANDLER_W-1:0]       handler_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lhr_pkg::STATUS_W-1:0]        status_o,
  output logic [lhr_pkg::HANDLER_W-1:0]       handler_out_o,
  output logic [$clog2(MAX_NUMBER+1)-1:0]     number_out_o
);
  import lhr_pkg::*;

  localparam int unsigned NW   = $clog2(MAX_NUMBER + 1);
  localparam int unsigned NW1  = NW + 1;
  localparam int unsigned DD   = LOW_SLOTS + SYSTEM_HIGH_SLOTS;
  localparam int unsigned DAW  = $clog2(DD);
  localparam int unsigned UAW  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int unsigned UCW  = $clog2(USER_SLOTS + 1);
  localparam int unsigned UDW  = NW + HANDLER_W;
  localparam int          SYS_BASE   = int'(MAX_NUMBER) + 1 - int'(SYSTEM_HIGH_SLOTS);
  localparam int          SYS_LO_NUM = (SYS_BASE > int'(LOW_SLOTS)) ? SYS_BASE : int'(LOW_SLOTS);
  localparam bit          SYS_EN     = SYS_LO_NUM <= int'(MAX_NUMBER);
  localparam int          DIR_OFS    = int'(LOW_SLOTS) - SYS_BASE;
  localparam int unsigned TW   = ((DAW > NW1) ? DAW : NW1) + 1;
  localparam logic [TW-1:0]  OFS_T    = TW'(DIR_OFS);
  localparam logic [DAW-1:0] SYS_STOP = DAW'(SYS_LO_NUM + DIR_OFS);
  localparam logic [DAW-1:0] LOW_TOP  = DAW'(LOW_SLOTS - 1);
  localparam logic [DAW-1:0] DIR_LAST = DAW'(DD - 1);
  localparam logic [NW:0]    MAX_P1   = NW1'(MAX_NUMBER + 1);
  localparam logic [NW:0]    MAX_N    = NW1'(MAX_NUMBER);
  localparam logic [UCW-1:0] USER_FULL = UCW'(USER_SLOTS);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DCHK, S_DSRD, S_DSCK, S_URD, S_UCMP,
    S_SHRD, S_SHWR, S_RMRD, S_RMWR, S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [NW:0]           key_q, key_d;
  logic [HANDLER_W-1:0]  hin_q, hin_d;
  logic [UCW-1:0]        ucnt_q, ucnt_d;
  logic [UCW-1:0]        uptr_q, uptr_d;
  logic [UCW-1:0]        pos_q, pos_d;
  logic [NW-1:0]         best_q, best_d;
  logic                  best_vld_q, best_vld_d;
  logic [DAW-1:0]        dptr_q, dptr_d;
  logic [DAW-1:0]        dstop_q, dstop_d;
  logic                  sys_phase_q, sys_phase_d;
  logic                  clr_rsp_q, clr_rsp_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [HANDLER_W-1:0]  res_h_q, res_h_d;
  logic [NW-1:0]         res_n_q, res_n_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [HANDLER_W-1:0]  out_h_q, out_h_d;
  logic [NW-1:0]         out_n_q, out_n_d;

  logic [HANDLER_W-1:0]  dir_mem [DD];
  logic [UDW-1:0]        usr_mem [USER_SLOTS];
  logic [HANDLER_W-1:0]  dir_rdata_q;
  logic [UDW-1:0]        usr_rdata_q;
  logic                  dir_we, dir_re, usr_we, usr_re;
  logic [DAW-1:0]        dir_waddr, dir_raddr;
  logic [HANDLER_W-1:0]  dir_wdata;
  logic [UAW-1:0]        usr_waddr, usr_raddr;
  logic [UDW-1:0]        usr_wdata;

  logic [NW:0]           lim_c;
  logic [DAW-1:0]        dir_addr_c;
  logic [TW-1:0]         sys_top_c;
  logic [TW-1:0]         sys_num_c;
  logic [UCW-1:0]        uptr_m1, uptr_p1;
  logic [NW-1:0]         u_num;
  logic [HANDLER_W-1:0]  u_h;
  logic                  u_stop, u_eq;
  logic                  out_free;

  assign lim_c      = (lib_number_i > MAX_P1) ? MAX_P1 : lib_number_i;
  assign dir_addr_c = (int'(lib_number_i) < int'(LOW_SLOTS)) ? DAW'(lib_number_i)
                                                               : DAW'(TW'(lib_number_i) + OFS_T);
  assign sys_top_c  = TW'(lim_c) - TW'(1) + OFS_T;
  assign sys_num_c  = TW'(dptr_q) - OFS_T;
  assign uptr_m1    = uptr_q - 1'b1;
  assign uptr_p1    = uptr_q + 1'b1;
  assign u_num      = usr_rdata_q[UDW-1:HANDLER_W];
  assign u_h        = usr_rdata_q[HANDLER_W-1:0];
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    if (dir_re) dir_rdata_q <= dir_mem[dir_raddr];
    if (usr_we) usr_mem[usr_waddr] <= usr_wdata;
    if (usr_re) usr_rdata_q <= usr_mem[usr_raddr];
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    hin_d        = hin_q;
    ucnt_d       = ucnt_q;
    uptr_d       = uptr_q;
    pos_d        = pos_q;
    best_d       = best_q;
    best_vld_d   = best_vld_q;
    dptr_d       = dptr_q;
    dstop_d      = dstop_q;
    sys_phase_d  = sys_phase_q;
    clr_rsp_d    = clr_rsp_q;
    res_status_d = res_status_q;
    res_h_d      = res_h_q;
    res_n_d      = res_n_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_h_d      = out_h_q;
    out_n_d      = out_n_q;
    dir_we = 1'b0; dir_waddr = '0; dir_wdata = '0; dir_re = 1'b0; dir_raddr = '0;
    usr_we = 1'b0; usr_waddr = '0; usr_wdata = '0; usr_re = 1'b0; usr_raddr = '0;
    u_stop = 1'b0;
    u_eq   = 1'b0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLR: begin
        dir_we    = 1'b1;
        dir_waddr = dptr_q;
        if (dptr_q == DIR_LAST) begin
          if (clr_rsp_q) begin
            res_status_d = ST_OK;
            state_d      = S_RESP;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          dptr_d = dptr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_i;
          hin_d      = handler_in_i;
          key_d      = lim_c;
          best_vld_d = 1'b0;
          uptr_d     = '0;
          res_h_d    = '0;
          res_n_d    = '0;
          if (op_i == OP_CLEAR) begin
            dptr_d    = '0;
            clr_rsp_d = 1'b1;
            ucnt_d    = '0;
            state_d   = S_CLR;
          end else if (op_i == OP_NEXT_LOWER) begin
            if (SYS_EN && int'(lim_c) > SYS_LO_NUM) begin
              dptr_d      = DAW'(sys_top_c);
              dstop_d     = SYS_STOP;
              sys_phase_d = 1'b1;
              state_d     = S_DSRD;
            end else begin
              state_d = S_URD;
            end
          end else if (op_i > OP_CLEAR || lib_number_i > MAX_N ||
                       (op_i == OP_INSTALL && handler_in_i == '0)) begin
            res_status_d = ST_INVALID;
            state_d      = S_RESP;
          end else if (int'(lib_number_i) < int'(LOW_SLOTS) ||
                       int'(lib_number_i) >= SYS_BASE) begin
            dir_re    = 1'b1;
            dir_raddr = dir_addr_c;
            dptr_d    = dir_addr_c;
            state_d   = S_DCHK;
          end else begin
            state_d = S_URD;
          end
        end
      end
      S_DCHK: begin
        state_d = S_RESP;
        case (op_q)
          OP_LOOKUP: begin
            res_h_d      = dir_rdata_q;
            res_status_d = (dir_rdata_q != '0) ? ST_OK : ST_NOT_FOUND;
          end
          OP_INSTALL: begin
            if (dir_rdata_q == '0) begin
              dir_we       = 1'b1;
              dir_waddr    = dptr_q;
              dir_wdata    = hin_q;
              res_status_d = ST_OK;
            end else begin
              res_status_d = (dir_rdata_q == hin_q) ? ST_SAME : ST_CONFLICT;
            end
          end
          default: begin
            dir_we       = 1'b1;
            dir_waddr    = dptr_q;
            res_status_d = (dir_rdata_q != '0) ? ST_OK : ST_NOT_FOUND;
          end
        endcase
      end
      S_DSRD: begin
        dir_re    = 1'b1;
        dir_raddr = dptr_q;
        state_d   = S_DSCK;
      end
      S_DSCK: begin
        if (dir_rdata_q != '0) begin
          res_status_d = ST_OK;
          res_n_d      = sys_phase_q ? NW'(sys_num_c) : NW'(dptr_q);
          state_d      = S_RESP;
        end else if (dptr_q == dstop_q) begin
          if (sys_phase_q) begin
            state_d = S_URD;
          end else begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_RESP;
          end
        end else begin
          dptr_d  = dptr_q - 1'b1;
          state_d = S_DSRD;
        end
      end
      S_URD: begin
        if (uptr_q == ucnt_q) begin
          u_stop = 1'b1;
        end else begin
          usr_re    = 1'b1;
          usr_raddr = uptr_q[UAW-1:0];
          state_d   = S_UCMP;
        end
      end
      S_UCMP: begin
        if ({1'b0, u_num} >= key_q) begin
          u_stop = 1'b1;
          u_eq   = ({1'b0, u_num} == key_q);
        end else begin
          best_d     = u_num;
          best_vld_d = 1'b1;
          uptr_d     = uptr_p1;
          state_d    = S_URD;
        end
      end
      S_SHRD: begin
        if (uptr_q == pos_q) begin
          usr_we       = 1'b1;
          usr_waddr    = pos_q[UAW-1:0];
          usr_wdata    = {key_q[NW-1:0], hin_q};
          ucnt_d       = ucnt_q + 1'b1;
          res_status_d = ST_OK;
          state_d      = S_RESP;
        end else begin
          usr_re    = 1'b1;
          usr_raddr = uptr_m1[UAW-1:0];
          state_d   = S_SHWR;
        end
      end
      S_SHWR: begin
        usr_we    = 1'b1;
        usr_waddr = uptr_q[UAW-1:0];
        usr_wdata = usr_rdata_q;
        uptr_d    = uptr_m1;
        state_d   = S_SHRD;
      end
      S_RMRD: begin
        if (uptr_p1 == ucnt_q) begin
          usr_we       = 1'b1;
          usr_waddr    = uptr_q[UAW-1:0];
          ucnt_d       = ucnt_q - 1'b1;
          res_status_d = ST_OK;
          state_d      = S_RESP;
        end else begin
          usr_re    = 1'b1;
          usr_raddr = uptr_p1[UAW-1:0];
          state_d   = S_RMWR;
        end
      end
      S_RMWR: begin
        usr_we    = 1'b1;
        usr_waddr = uptr_q[UAW-1:0];
        usr_wdata = usr_rdata_q;
        uptr_d    = uptr_p1;
        state_d   = S_RMRD;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_h_d      = res_h_q;
          out_n_d      = res_n_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (u_stop) begin
      pos_d   = uptr_q;
      state_d = S_RESP;
      case (op_q)
        OP_LOOKUP: begin
          res_h_d      = u_eq ? u_h : '0;
          res_status_d = u_eq ? ST_OK : ST_NOT_FOUND;
        end
        OP_INSTALL: begin
          if (u_eq) begin
            res_status_d = (u_h == hin_q) ? ST_SAME : ST_CONFLICT;
          end else if (ucnt_q == USER_FULL) begin
            res_status_d = ST_FULL;
          end else begin
            uptr_d  = ucnt_q;
            state_d = S_SHRD;
          end
        end
        OP_REMOVE: begin
          if (u_eq) begin
            state_d = S_RMRD;
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end
        default: begin
          if (best_vld_q) begin
            res_status_d = ST_OK;
            res_n_d      = best_q;
          end else if (key_q != '0) begin
            dptr_d      = (int'(key_q) < int'(LOW_SLOTS)) ? DAW'(key_q - 1'b1) : LOW_TOP;
            dstop_d     = '0;
            sys_phase_d = 1'b0;
            state_d     = S_DSRD;
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      op_q         <= '0;
      key_q        <= '0;
      hin_q        <= '0;
      ucnt_q       <= '0;
      uptr_q       <= '0;
      pos_q        <= '0;
      best_q       <= '0;
      best_vld_q   <= 1'b0;
      dptr_q       <= '0;
      dstop_q      <= '0;
      sys_phase_q  <= 1'b0;
      clr_rsp_q    <= 1'b0;
      res_status_q <= '0;
      res_h_q      <= '0;
      res_n_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_h_q      <= '0;
      out_n_q      <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      key_q        <= key_d;
      hin_q        <= hin_d;
      ucnt_q       <= ucnt_d;
      uptr_q       <= uptr_d;
      pos_q        <= pos_d;
      best_q       <= best_d;
      best_vld_q   <= best_vld_d;
      dptr_q       <= dptr_d;
      dstop_q      <= dstop_d;
      sys_phase_q  <= sys_phase_d;
      clr_rsp_q    <= clr_rsp_d;
      res_status_q <= res_status_d;
      res_h_q      <= res_h_d;
      res_n_q      <= res_n_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_h_q      <= out_h_d;
      out_n_q      <= out_n_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign handler_out_o = out_h_q;
  assign number_out_o  = out_n_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted but block still ready");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucnt_q <= USER_FULL)
    else $error("user list count beyond capacity");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_RESP)
    else $error("result raised outside response state");

  a_usr_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    usr_we |-> state_q == S_SHRD || state_q == S_SHWR || state_q == S_RMRD ||
               state_q == S_RMWR)
    else $error("user list written outside a shift");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lhr_pkg::*;

  localparam int unsigned NUM_TOP  = 4096;
  localparam int unsigned LOW_N    = 256;
  localparam int unsigned SYS_N    = 64;
  localparam int unsigned USER_N   = 64;
  localparam int unsigned SYS_BASE = NUM_TOP - SYS_N;
  localparam int unsigned LIMIT_CYCLES = 1500000;

  typedef struct packed {
    logic [2:0]  op;
    logic [12:0] num;
    logic [15:0] hnd;
  } item_t;

  typedef struct packed {
    status_e     st;
    logic [15:0] hnd;
    logic [11:0] num;
  } reply_t;

  typedef struct packed {
    item_t  it;
    logic   fixed;
    reply_t rep;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [12:0] lib_number_i;
  logic [15:0] handler_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [15:0] handler_out_o;
  logic [11:0] number_out_o;

  library_handler_registry u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .lib_number_i  (lib_number_i),
    .handler_in_i  (handler_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .handler_out_o (handler_out_o),
    .number_out_o  (number_out_o)
  );

  // shadow registry: one handler per number, 0 empty
  logic [15:0] reg_map [NUM_TOP];
  int          user_used;
  reply_t      pending_replies [$];
  int          n_errors;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  longint      cycle_cnt;
  logic [15:0] user_keys [$];

  function automatic logic is_user(int unsigned n);
    return n >= LOW_N && n < SYS_BASE;
  endfunction

  function automatic reply_t registry_apply(item_t it);
    reply_t r;
    int unsigned n;
    int unsigned lim;
    r = '{st: ST_INVALID, hnd: '0, num: '0};
    n = it.num;
    if (it.op == OP_CLEAR) begin
      foreach (reg_map[i]) reg_map[i] = '0;
      user_used = 0;
      r.st = ST_OK;
    end else if (it.op == OP_NEXT_LOWER) begin
      lim = (n > NUM_TOP) ? NUM_TOP : n;
      r.st = ST_NOT_FOUND;
      for (int i = int'(lim) - 1; i >= 0; i--) begin
        if (reg_map[i] != 0) begin
          r.st = ST_OK;
          r.num = i[11:0];
          break;
        end
      end
    end else if (it.op <= OP_REMOVE && n < NUM_TOP) begin
      case (op_e'(it.op))
        OP_LOOKUP: begin
          r.hnd = reg_map[n];
          r.st = (reg_map[n] != 0) ? ST_OK : ST_NOT_FOUND;
        end
        OP_INSTALL: begin
          if (it.hnd == 0) r.st = ST_INVALID;
          else if (reg_map[n] == it.hnd) r.st = ST_SAME;
          else if (reg_map[n] != 0) r.st = ST_CONFLICT;
          else if (is_user(n) && user_used >= USER_N) r.st = ST_FULL;
          else begin
            reg_map[n] = it.hnd;
            if (is_user(n)) user_used++;
            r.st = ST_OK;
          end
        end
        default: begin
          r.st = (reg_map[n] != 0) ? ST_OK : ST_NOT_FOUND;
          if (reg_map[n] != 0 && is_user(n)) user_used--;
          reg_map[n] = '0;
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    n_errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          reply_t w;
          w = pending_replies.pop_front();
          if (status_o !== w.st) report_mismatch("status", status_o, w.st);
          if (handler_out_o !== w.hnd) report_mismatch("handler", handler_out_o, w.hnd);
          if (number_out_o !== w.num) report_mismatch("number", number_out_o, w.num);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_item(item_t it, logic fixed, reply_t want);
    reply_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= it.op;
    lib_number_i <= it.num;
    handler_in_i <= it.hnd;
    do @(posedge clk_i); while (in_stall_o);
    p = registry_apply(it);
    if (fixed && p != want) report_mismatch("table row", p, want);
    pending_replies.push_back(fixed ? want : p);
  endtask

  function automatic logic [12:0] pick_number();
    int k;
    k = $urandom_range(99);
    if (k < 45 && user_keys.size() > 0) return 13'(user_keys[$urandom_range(user_keys.size() - 1)]);
    if (k < 60) return 13'($urandom_range(LOW_N - 1));
    if (k < 70) return 13'($urandom_range(NUM_TOP - 1, SYS_BASE));
    if (k < 73) return 13'($urandom_range(8191, NUM_TOP));
    return 13'($urandom_range(SYS_BASE - 1, LOW_N));
  endfunction

  task automatic random_phase(int count);
    item_t it;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      it.num = pick_number();
      it.hnd = ($urandom_range(15) == 0) ? 16'h0 : 16'($urandom_range(4, 1));
      if ($urandom_range(9) == 0) it.hnd = 16'($urandom);
      if (k < 40) begin
        it.op = OP_INSTALL;
        if (is_user(it.num) && user_keys.size() < 80) user_keys.push_back(16'(it.num));
      end
      else if (k < 60) it.op = OP_LOOKUP;
      else if (k < 75) it.op = OP_REMOVE;
      else if (k < 92) begin
        it.op = OP_NEXT_LOWER;
        if ($urandom_range(4) == 0) it.num = 13'(NUM_TOP);
      end
      else if (k < 94) it.op = OP_CLEAR;
      else it.op = 3'($urandom_range(7, 5));
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
  endtask

  row_t rows [$];

  initial begin
    item_t  fill;
    n_errors = 0;
    user_used = 0;
    foreach (reg_map[i]) reg_map[i] = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    in_valid_i = 1'b0;
    op_i = '0;
    lib_number_i = '0;
    handler_in_i = '0;
    rst_ni = 1'b0;
    rows = '{
      '{'{OP_LOOKUP, 13'd0, 16'd0}, 1'b1, '{ST_NOT_FOUND, 16'd0, 12'd0}},
      '{'{OP_NEXT_LOWER, 13'd4096, 16'd0}, 1'b1, '{ST_NOT_FOUND, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd0, 16'hFFFF}, 1'b1, '{ST_OK, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd0, 16'hFFFF}, 1'b1, '{ST_SAME, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd0, 16'h0001}, 1'b1, '{ST_CONFLICT, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd5, 16'h0000}, 1'b1, '{ST_INVALID, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd4095, 16'hA5A5}, 1'b1, '{ST_OK, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd4096, 16'h0001}, 1'b1, '{ST_INVALID, 16'd0, 12'd0}},
      '{'{OP_LOOKUP, 13'd8191, 16'd0}, 1'b1, '{ST_INVALID, 16'd0, 12'd0}},
      '{'{OP_REMOVE, 13'd4096, 16'd0}, 1'b1, '{ST_INVALID, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd256, 16'h5A5A}, 1'b1, '{ST_OK, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd4031, 16'h0002}, 1'b1, '{ST_OK, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd4032, 16'h0003}, 1'b1, '{ST_OK, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd255, 16'h0004}, 1'b1, '{ST_OK, 16'd0, 12'd0}},
      '{'{OP_INSTALL, 13'd256, 16'h0007}, 1'b1, '{ST_CONFLICT, 16'd0, 12'd0}},
      '{'{OP_LOOKUP, 13'd4095, 16'd0}, 1'b1, '{ST_OK, 16'hA5A5, 12'd0}},
      '{'{OP_NEXT_LOWER, 13'd8191, 16'd0}, 1'b1, '{ST_OK, 16'd0, 12'd4095}},
      '{'{OP_NEXT_LOWER, 13'd4032, 16'd0}, 1'b1, '{ST_OK, 16'd0, 12'd4031}},
      '{'{OP_NEXT_LOWER, 13'd256, 16'd0}, 1'b1, '{ST_OK, 16'd0, 12'd255}},
      '{'{OP_NEXT_LOWER, 13'd0, 16'd0}, 1'b1, '{ST_NOT_FOUND, 16'd0, 12'd0}},
      '{'{OP_REMOVE, 13'd256, 16'd0}, 1'b1, '{ST_OK, 16'd0, 12'd0}},
      '{'{OP_REMOVE, 13'd256, 16'd0}, 1'b1, '{ST_NOT_FOUND, 16'd0, 12'd0}},
      '{'{3'd5, 13'd1, 16'd1}, 1'b1, '{ST_INVALID, 16'd0, 12'd0}},
      '{'{3'd7, 13'd1, 16'd1}, 1'b1, '{ST_INVALID, 16'd0, 12'd0}},
      '{'{OP_CLEAR, 13'd0, 16'd0}, 1'b1, '{ST_OK, 16'd0, 12'd0}}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].rep);
    // fill the user list to overflow
    for (int i = 0; i < USER_N + 2; i++) begin
      fill = '{OP_INSTALL, 13'(LOW_N + 3 + 47 * i), 16'(i + 1)};
      send_item(fill, 1'b0, '0);
    end
    random_phase(50);
    send_idle_pct = 60;
    random_phase(100);
    send_idle_pct = 0;
    recv_stall_pct = 60;
    random_phase(100);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    hold_cycles = 3000;
    random_phase(70);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(40);
    drain();
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
